// File: rtl/infix_to_postfix_converter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix-to-postfix converter
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define ITP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// next-cycle implication
`define ITP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`endif

// File: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and helpers shared by the infix-to-postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int REF_BITS        = 16;
    localparam int ENTRY_W         = 5;

    localparam logic [15:0] REF_MASK =
        (REF_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << REF_BITS) - 32'd1);

    // token kinds
    localparam logic [2:0] TOK_OPERAND  = 3'd0;
    localparam logic [2:0] TOK_FUNC     = 3'd1;
    localparam logic [2:0] TOK_OPERATOR = 3'd2;
    localparam logic [2:0] TOK_LPAREN   = 3'd3;
    localparam logic [2:0] TOK_RPAREN   = 3'd4;
    localparam logic [2:0] TOK_END      = 3'd5;

    // operator codes
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_DIV    = 3'd3;
    localparam logic [2:0] OP_POW    = 3'd4;
    localparam logic [2:0] OP_ASSIGN = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_OPERAND  = 3'd0;
    localparam logic [2:0] KIND_OPERATOR = 3'd1;
    localparam logic [2:0] KIND_FUNCTION = 3'd2;
    localparam logic [2:0] KIND_END      = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_PAREN    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    // stack entries: operator codes as is, plus these
    localparam logic [ENTRY_W-1:0] ENT_FUNC   = 5'd6;
    localparam logic [ENTRY_W-1:0] ENT_LPAREN = 5'd7;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  op_code;
        logic [15:0] token_ref;
        logic        is_name;
    } tok_t;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [2:0]  out_op;
        logic [15:0] out_ref;
        logic        out_is_name;
        logic [1:0]  error_code;
        logic        last;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_RPF,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        MODE_OPR,
        MODE_RP,
        MODE_END
    } mode_t;

    function automatic logic [2:0] prec(input logic [ENTRY_W-1:0] entry);
        logic [2:0] p;
        p = 3'd0;
        if (entry == {2'b00, OP_POW})
            p = 3'd4;
        else if (entry == {2'b00, OP_MUL} || entry == {2'b00, OP_DIV})
            p = 3'd3;
        else if (entry == {2'b00, OP_ADD} || entry == {2'b00, OP_SUB})
            p = 3'd2;
        return p;
    endfunction

    function automatic res_t mk_res(input logic [2:0] kind, input logic [2:0] op,
                                    input logic [15:0] rf, input logic nm,
                                    input logic [1:0] err);
        res_t r;
        r.out_kind    = kind;
        r.out_op      = op;
        r.out_ref     = rf;
        r.out_is_name = nm;
        r.error_code  = err;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic res_t entry_res(input logic [ENTRY_W-1:0] entry);
        res_t r;
        if (entry == ENT_FUNC)
            r = mk_res(KIND_FUNCTION, OP_ADD, 16'd0, 1'b0, ERR_NONE);
        else
            r = mk_res(KIND_OPERATOR, entry[2:0], 16'd0, 1'b0, ERR_NONE);
        return r;
    endfunction

endpackage

// File: rtl/itp_stack_ram.sv
// ----------------------------------------------------------------------------
// itp_stack_ram
// Operator stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itp_stack_ram #(
    parameter int DEPTH = itp_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [itp_pkg::ENTRY_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [itp_pkg::ENTRY_W-1:0] rd_data
);
    import itp_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/infix_to_postfix_converter_core.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter: classified infix tokens in, postfix tokens out.
// ----------------------------------------------------------------------------
// One token is taken at a time; tok_stall is high while a token is worked on.
// A function or left paren that fits on the stack is pushed without a stall;
// an operand passes the pending stage before it reaches the result register.
// Operators, right parens and end tokens pop one stack entry at a time; each
// pop issues the read of the entry below the top, as the read port of the
// stack memory is registered. Every result is held one stage before the
// result register so that its last flag is known; result-side stalls hold it.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tok_valid,
    output logic          tok_stall,
    input  itp_pkg::tok_t tok,
    output logic          res_valid,
    input  logic          res_stall,
    output itp_pkg::res_t res
);
    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    state_t        state_reg, state_next;
    mode_t         mode_reg, mode_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    code_reg, code_next;
    logic          pend_valid_reg, pend_valid_next;
    res_t          pend_reg, pend_next;
    logic          res_valid_reg, res_valid_next;
    res_t          res_reg, res_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] top;

    logic          accept;
    logic          out_free;
    logic          can_emit;
    logic          emit_en;
    res_t          emit_res;
    logic          flush_en;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic [2:0]    p_in;
    logic [2:0]    p_top;
    logic          pop_ok;

    itp_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (top)
    );

    assign tok_stall = (state_reg != ST_IDLE);
    assign accept    = tok_valid && !tok_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign can_emit  = !pend_valid_reg || out_free;
    assign cnt_m1    = cnt_reg - ONE_C;
    assign cnt_m2    = cnt_reg - TWO_C;
    assign p_in      = prec({2'b00, code_reg});
    assign p_top     = prec(top);
    assign pop_ok    = (cnt_reg != '0) && (top != ENT_LPAREN) &&
                       ((p_in < p_top) || ((p_in == p_top) && (code_reg != OP_POW)));

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        code_next       = code_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[AW-1:0];
        wr_data         = ENT_LPAREN;
        rd_en           = 1'b0;
        rd_addr         = '0;
        emit_en         = 1'b0;
        emit_res        = mk_res(KIND_ERROR, OP_ADD, 16'd0, 1'b0, ERR_OVERFLOW);
        flush_en        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                rd_en   = 1'b1;
                rd_addr = (cnt_reg == '0) ? '0 : cnt_m1[AW-1:0];
                if (accept)
                begin
                    code_next = tok.op_code;
                    case (tok.operation)
                        TOK_OPERAND:
                        begin
                            emit_en    = 1'b1;
                            emit_res   = mk_res(KIND_OPERAND, OP_ADD,
                                                tok.token_ref & REF_MASK,
                                                tok.is_name, ERR_NONE);
                            state_next = ST_FLUSH;
                        end
                        TOK_FUNC, TOK_LPAREN:
                        begin
                            if (cnt_reg == DEPTH_C)
                            begin
                                emit_en    = 1'b1;
                                cnt_next   = '0;
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_data  = (tok.operation == TOK_FUNC) ? ENT_FUNC : ENT_LPAREN;
                                cnt_next = cnt_reg + ONE_C;
                            end
                        end
                        TOK_OPERATOR:
                        begin
                            if (tok.op_code inside {[OP_ADD:OP_POW]})
                            begin
                                mode_next  = MODE_OPR;
                                state_next = ST_POP;
                            end
                        end
                        TOK_RPAREN:
                        begin
                            mode_next  = MODE_RP;
                            state_next = ST_POP;
                        end
                        TOK_END:
                        begin
                            mode_next  = MODE_END;
                            state_next = ST_POP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                rd_addr = (cnt_reg < TWO_C) ? '0 : cnt_m2[AW-1:0];
                if (can_emit)
                begin
                    case (mode_reg)
                        MODE_OPR:
                        begin
                            if (pop_ok)
                            begin
                                emit_en  = 1'b1;
                                emit_res = entry_res(top);
                                cnt_next = cnt_m1;
                                rd_en    = 1'b1;
                            end
                            else if (cnt_reg == DEPTH_C)
                            begin
                                emit_en    = 1'b1;
                                cnt_next   = '0;
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = {2'b00, code_reg};
                                cnt_next   = cnt_reg + ONE_C;
                                state_next = ST_FLUSH;
                            end
                        end
                        MODE_RP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                emit_en    = 1'b1;
                                emit_res   = mk_res(KIND_ERROR, OP_ADD, 16'd0, 1'b0,
                                                    ERR_PAREN);
                                state_next = ST_FLUSH;
                            end
                            else if (top != ENT_LPAREN)
                            begin
                                emit_en  = 1'b1;
                                emit_res = entry_res(top);
                                cnt_next = cnt_m1;
                                rd_en    = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = cnt_m1;
                                rd_en      = 1'b1;
                                state_next = ST_RPF;
                            end
                        end
                        MODE_END:
                        begin
                            if (cnt_reg == '0)
                            begin
                                emit_en    = 1'b1;
                                emit_res   = mk_res(KIND_END, OP_ADD, 16'd0, 1'b0, ERR_NONE);
                                state_next = ST_FLUSH;
                            end
                            else if (top == ENT_LPAREN)
                            begin
                                emit_en    = 1'b1;
                                emit_res   = mk_res(KIND_ERROR, OP_ADD, 16'd0, 1'b0,
                                                    ERR_PAREN);
                                cnt_next   = '0;
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                emit_en  = 1'b1;
                                emit_res = entry_res(top);
                                cnt_next = cnt_m1;
                                rd_en    = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FLUSH;
                        end
                    endcase
                end
            end

            ST_RPF:
            begin
                if (cnt_reg != '0 && top == ENT_FUNC)
                begin
                    if (can_emit)
                    begin
                        emit_en    = 1'b1;
                        emit_res   = entry_res(top);
                        cnt_next   = cnt_m1;
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    flush_en   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // pending result moves on once the next one is known
        if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                res_next       = pend_reg;
                res_next.last  = 1'b0;
                res_valid_next = 1'b1;
            end
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
        end
        else if (flush_en)
        begin
            res_next        = pend_reg;
            res_next.last   = 1'b1;
            res_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_OPR;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks on the converter's result channel.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_core_macros.svh"

module itp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_stall,
    input itp_pkg::res_t res
);
    import itp_pkg::*;

    // a stalled transfer keeps its payload
    `ITP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
    // error results carry a code, others none
    `ITP_ASSERT_NOW(a_err_code, res_valid, (res.out_kind == KIND_ERROR) == (res.error_code != ERR_NONE))
    // end marker and error close the token's results
    `ITP_ASSERT_NOW(a_term_last, res_valid && (res.out_kind == KIND_END || res.out_kind == KIND_ERROR), res.last)
    // only operands carry a handle
    `ITP_ASSERT_NOW(a_ref_zero, res_valid && res.out_kind != KIND_OPERAND, res.out_ref == 16'd0 && !res.out_is_name)

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (.*);
